@@ rtl/core/mmp_pkg.sv @@
// ----------------------------------------------------------------------------
// mmp_pkg
// Shared types, op codes and constants of the mouse motion pacer.
// ----------------------------------------------------------------------------
package mmp_pkg;

  localparam logic [2:0] OP_MOVE       = 3'd0;
  localparam logic [2:0] OP_WARP       = 3'd1;
  localparam logic [2:0] OP_BUTTON     = 3'd2;
  localparam logic [2:0] OP_PEEK       = 3'd3;
  localparam logic [2:0] OP_SYNC       = 3'd4;
  localparam logic [2:0] OP_SOFT_RESET = 3'd5;

  localparam int STALL_LIMIT_DEFAULT = 30;

  localparam logic signed [10:0] HOME_X_LOAD = -11'sd768;
  localparam logic signed [10:0] HOME_Y_LOAD = -11'sd480;
  localparam logic signed [11:0] MAX_COL     = 12'sd639;
  localparam logic signed [11:0] MAX_ROW     = 12'sd399;
  localparam logic [6:0]         ROOM_SLOW   = 7'd15;
  localparam logic [6:0]         ROOM_FAST   = 7'd127;
  localparam logic signed [16:0] BYPASS_ROOM = 17'sd32767;
  localparam logic signed [16:0] SAT_MAX     = 17'sd32767;
  localparam logic signed [16:0] SAT_MIN     = -17'sd32768;

  localparam logic [7:0] BTN_RESET     = 8'ha0;
  localparam logic [7:0] BTN_PRIMARY   = 8'h80;
  localparam logic [7:0] BTN_SECONDARY = 8'h20;

  typedef struct packed {
    logic [2:0]          op;
    logic signed [15:0]  delta_x;
    logic signed [15:0]  delta_y;
    logic signed [11:0]  target_x;
    logic signed [11:0]  target_y;
    logic [31:0]         warp_tag;
    logic                button_sel;
    logic                button_down;
    logic signed [7:0]   held_x;
    logic signed [7:0]   held_y;
  } mmp_in_t;

  typedef struct packed {
    logic signed [15:0] step_x;
    logic signed [15:0] step_y;
    logic [7:0]         button_bits;
    logic [31:0]        warp_done_tag;
  } mmp_out_t;

  typedef struct packed {
    logic signed [15:0] step;
    logic signed [10:0] home;
    logic               homing;
    logic signed [15:0] pending;
  } mmp_axis_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > SAT_MAX) begin
      r = 16'sh7fff;
    end else if (v < SAT_MIN) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/mmp_axis.sv @@
// ----------------------------------------------------------------------------
// mmp_axis
// One axis of a sync step: latch room, source choice, clamped step and the
// updated home, homing and pending values.
// ----------------------------------------------------------------------------
module mmp_axis (
  input  logic signed [15:0] pending,
  input  logic signed [10:0] home,
  input  logic               homing,
  input  logic signed [7:0]  held,
  input  logic               slow_mode,
  input  logic               bypass,
  output mmp_pkg::mmp_axis_t result
);
  import mmp_pkg::*;

  logic [7:0]         mag;
  logic signed [8:0]  room_small;
  logic signed [16:0] room;
  logic signed [16:0] src;
  logic signed [16:0] st;
  logic               use_home;
  logic               hold;

  always_comb begin
    mag        = held[7] ? 8'(~held + 8'sd1) : 8'(held);
    room_small = $signed({2'b00, (slow_mode ? ROOM_SLOW : ROOM_FAST)}) - $signed({1'b0, mag});
    room       = bypass ? BYPASS_ROOM : 17'(room_small);
    use_home   = (home != 11'sd0);
    hold       = !use_home && homing && (held != 8'sd0) && !bypass;
    src        = use_home ? 17'(home) : 17'(pending);
    st         = '0;

    result.step    = '0;
    result.home    = home;
    result.homing  = homing;
    result.pending = pending;

    if (!use_home && !hold) begin
      result.homing = 1'b0;
    end
    if (!hold && (room > 17'sd0) && (src != 17'sd0)) begin
      if (src > room) begin
        st = room;
      end else if (src < -room) begin
        st = -room;
      end else begin
        st = src;
      end
      result.step = st[15:0];
      if (use_home) begin
        result.home = home - st[10:0];
      end else begin
        result.pending = pending - st[15:0];
      end
    end
  end

endmodule

@@ rtl/core/mmp_datapath.sv @@
// ----------------------------------------------------------------------------
// mmp_datapath
// Pacer state and the single-pass update for one transaction.
// ----------------------------------------------------------------------------
module mmp_datapath #(
  parameter int STALL_LIMIT = mmp_pkg::STALL_LIMIT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  mmp_pkg::mmp_in_t  item,
  input  logic              slow_mode,
  output mmp_pkg::mmp_out_t result
);
  import mmp_pkg::*;

  localparam int StallW = $clog2(STALL_LIMIT + 1);
  localparam logic [StallW-1:0] StallMax = StallW'(STALL_LIMIT);

  logic signed [15:0] count_x, count_x_next;
  logic signed [15:0] count_y, count_y_next;
  logic signed [10:0] home_x, home_x_next;
  logic signed [10:0] home_y, home_y_next;
  logic               seek_x, seek_x_next;
  logic               seek_y, seek_y_next;
  logic [StallW-1:0]  stall, stall_next;
  logic [31:0]        warp_gen, warp_gen_next;
  logic [31:0]        completed_gen, completed_gen_next;
  logic [7:0]         button, button_next;

  logic               bypass;
  mmp_axis_t          ax_x;
  mmp_axis_t          ax_y;
  logic signed [16:0] sum_x, sum_y, peek_x, peek_y;
  logic signed [11:0] tx, ty;
  logic [7:0]         bit_sel;
  logic               work;
  logic               held_any;
  logic               moved;

  assign bypass = (stall >= StallMax);

  mmp_axis u_axis_x (
    .pending   (count_x),
    .home      (home_x),
    .homing    (seek_x),
    .held      (item.held_x),
    .slow_mode (slow_mode),
    .bypass    (bypass),
    .result    (ax_x)
  );

  mmp_axis u_axis_y (
    .pending   (count_y),
    .home      (home_y),
    .homing    (seek_y),
    .held      (item.held_y),
    .slow_mode (slow_mode),
    .bypass    (bypass),
    .result    (ax_y)
  );

  always_comb begin
    count_x_next       = count_x;
    count_y_next       = count_y;
    home_x_next        = home_x;
    home_y_next        = home_y;
    seek_x_next        = seek_x;
    seek_y_next        = seek_y;
    stall_next         = stall;
    warp_gen_next      = warp_gen;
    completed_gen_next = completed_gen;
    button_next        = button;
    result.step_x      = '0;
    result.step_y      = '0;

    sum_x    = 17'(count_x) + 17'(item.delta_x);
    sum_y    = 17'(count_y) + 17'(item.delta_y);
    peek_x   = 17'(home_x) + 17'(count_x);
    peek_y   = 17'(home_y) + 17'(count_y);
    bit_sel  = item.button_sel ? BTN_PRIMARY : BTN_SECONDARY;
    held_any = (item.held_x != 8'sd0) || (item.held_y != 8'sd0);
    work     = (ax_x.home != 11'sd0) || (ax_y.home != 11'sd0) ||
               (ax_x.pending != 16'sd0) || (ax_y.pending != 16'sd0) ||
               ax_x.homing || ax_y.homing;
    moved    = (ax_x.step != 16'sd0) || (ax_y.step != 16'sd0);

    if (item.target_x < 12'sd0) begin
      tx = 12'sd0;
    end else if (item.target_x > MAX_COL) begin
      tx = MAX_COL;
    end else begin
      tx = item.target_x;
    end
    if (item.target_y < 12'sd0) begin
      ty = 12'sd0;
    end else if (item.target_y > MAX_ROW) begin
      ty = MAX_ROW;
    end else begin
      ty = item.target_y;
    end

    case (item.op)
      OP_MOVE: begin
        count_x_next = sat16(sum_x);
        count_y_next = sat16(sum_y);
      end
      OP_WARP: begin
        home_x_next   = HOME_X_LOAD;
        home_y_next   = HOME_Y_LOAD;
        seek_x_next   = 1'b1;
        seek_y_next   = 1'b1;
        count_x_next  = 16'(tx);
        count_y_next  = 16'(ty);
        stall_next    = '0;
        warp_gen_next = item.warp_tag;
      end
      OP_BUTTON: begin
        if (item.button_down) begin
          button_next = button & ~bit_sel;
        end else begin
          button_next = button | bit_sel;
        end
      end
      OP_PEEK: begin
        result.step_x = sat16(peek_x);
        result.step_y = sat16(peek_y);
      end
      OP_SYNC: begin
        home_x_next   = ax_x.home;
        home_y_next   = ax_y.home;
        seek_x_next   = ax_x.homing;
        seek_y_next   = ax_y.homing;
        count_x_next  = ax_x.pending;
        count_y_next  = ax_y.pending;
        result.step_x = ax_x.step;
        result.step_y = ax_y.step;
        if (moved || (!work && !held_any)) begin
          stall_next = '0;
        end else if (stall < StallMax) begin
          stall_next = stall + 1'b1;
        end
        if (!work && !moved && (!held_any || (stall_next >= StallMax))) begin
          completed_gen_next = warp_gen;
        end
      end
      OP_SOFT_RESET: begin
        count_x_next       = '0;
        count_y_next       = '0;
        home_x_next        = '0;
        home_y_next        = '0;
        seek_x_next        = 1'b0;
        seek_y_next        = 1'b0;
        stall_next         = '0;
        button_next        = BTN_RESET;
        completed_gen_next = warp_gen;
      end
      default: begin
      end
    endcase

    result.button_bits   = button_next;
    result.warp_done_tag = completed_gen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_x       <= '0;
      count_y       <= '0;
      home_x        <= '0;
      home_y        <= '0;
      seek_x        <= 1'b0;
      seek_y        <= 1'b0;
      stall         <= '0;
      warp_gen      <= '0;
      completed_gen <= '0;
      button        <= BTN_RESET;
    end else if (go) begin
      count_x       <= count_x_next;
      count_y       <= count_y_next;
      home_x        <= home_x_next;
      home_y        <= home_y_next;
      seek_x        <= seek_x_next;
      seek_y        <= seek_y_next;
      stall         <= stall_next;
      warp_gen      <= warp_gen_next;
      completed_gen <= completed_gen_next;
      button        <= button_next;
    end
  end

  a_stall_bound: assert property (@(posedge clk) disable iff (rst) stall <= StallMax)
    else $error("stall count above limit");

  a_home_needs_homing: assert property (@(posedge clk) disable iff (rst)
    ((home_x != 11'sd0) |-> seek_x) and ((home_y != 11'sd0) |-> seek_y))
    else $error("home offset left without homing flag");

  a_home_sign: assert property (@(posedge clk) disable iff (rst)
    (home_x <= 11'sd0) && (home_y <= 11'sd0))
    else $error("home offset became positive");

  a_soft_reset: assert property (@(posedge clk) disable iff (rst)
    (go && (item.op == OP_SOFT_RESET)) |=>
      (button == BTN_RESET) && (stall == '0) && (completed_gen == warp_gen))
    else $error("soft reset did not clear state");

endmodule

@@ rtl/core/mouse_motion_pacer.sv @@
// ----------------------------------------------------------------------------
// mouse_motion_pacer
// Paces relative mouse motion, warps and button changes toward a guest latch.
// ----------------------------------------------------------------------------
// an accepted transaction waits in the input register until the result
// register can take it; its result is then registered there, raising out_valid
// throughput: one transaction per cycle while the output is not stalled, with
// a combinational state update between the input and result registers
// reset: synchronous rst empties both pipeline registers, clears slow_mode and
// all motion state, and sets the button byte to 0xa0
module mouse_motion_pacer #(
  parameter int STALL_LIMIT = mmp_pkg::STALL_LIMIT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mmp_pkg::mmp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mmp_pkg::mmp_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import mmp_pkg::*;

  logic     slow_mode;
  logic     s1_valid;
  mmp_in_t  s1_data;
  logic     s1_go;
  logic     o_valid;
  mmp_out_t o_data;
  mmp_out_t dp_result;

  assign s1_go     = s1_valid && (!o_valid || out_ready);
  assign in_ready  = !s1_valid || s1_go;
  assign out_valid = o_valid;
  assign out_data  = o_data;

  mmp_datapath #(
    .STALL_LIMIT (STALL_LIMIT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .go        (s1_go),
    .item      (s1_data),
    .slow_mode (slow_mode),
    .result    (dp_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_mode <= 1'b0;
      s1_valid  <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        slow_mode <= cfg_wdata;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_go) begin
        o_valid <= 1'b1;
      end else if (out_ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
    if (s1_go) begin
      o_data <= dp_result;
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_data)))
    else $error("input stage lost a waiting transaction");

  a_go_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_go |=> o_valid)
    else $error("processed transaction missing from result register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !o_valid))
    else $error("pipeline not empty after reset");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mouse motion pacer. A built-in predictor tracks
// the pending counts, homing offsets, stall counter, warp generations and the
// button byte, and computes the expected report for every accepted transaction.
// Directed sequences hit saturation, clamping, button edges, latch room and
// soft reset. Random sequences of warps, moves and syncs run under both room
// settings, with bursty input, a stalling output and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mmp_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int STALL_LIM      = STALL_LIMIT_DEFAULT;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_CAP      = 40;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  mmp_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mmp_out_t out_data;
  logic     cfg_we = 1'b0;
  logic     cfg_wdata = 1'b0;

  mouse_motion_pacer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted pacer state
  bit                 room_slow;
  logic signed [15:0] pend_x, pend_y;
  logic signed [10:0] home_x, home_y;
  logic               seek_x, seek_y;
  int                 stall_cnt;
  logic [31:0]        gen_warp, gen_done;
  logic [7:0]         btn;

  mmp_out_t queued_reports[$];
  int errors       = 0;
  int items_in     = 0;
  int results_out  = 0;
  int bypass_syncs = 0;
  int burst_left   = 0;
  int hold_req     = 0;

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic clear_motion_state();
    pend_x = '0;
    pend_y = '0;
    home_x = '0;
    home_y = '0;
    seek_x = 1'b0;
    seek_y = 1'b0;
    stall_cnt = 0;
    btn = BTN_RESET;
  endtask

  task automatic axis_advance(inout logic signed [10:0] home, inout logic homing,
                              inout logic signed [15:0] pending, input int held,
                              input int limit, input bit bypass,
                              output logic signed [15:0] step);
    int  mag, room, src, st;
    bit  from_home, waiting;
    mag = (held < 0) ? -held : held;
    room = bypass ? 32767 : limit - mag;
    st = 0;
    src = 0;
    from_home = 1'b0;
    waiting = 1'b0;
    if (home != 0) begin
      from_home = 1'b1;
      src = home;
    end else if (homing && held != 0 && !bypass) begin
      waiting = 1'b1;
    end else begin
      homing = 1'b0;
      src = pending;
    end
    if (!waiting && room > 0 && src != 0) begin
      st = clip(src, -room, room);
      if (from_home) begin
        home = 11'(src - st);
      end else begin
        pending = 16'(src - st);
      end
    end
    step = 16'(st);
  endtask

  task automatic advance_pacer(input mmp_in_t it, output mmp_out_t rep);
    logic signed [15:0] sx, sy;
    logic [7:0]         sel_bit;
    int                 hx, hy, limit;
    bit                 bypass, work, held;
    sx = '0;
    sy = '0;
    case (it.op)
      OP_MOVE: begin
        pend_x = 16'(clip(int'(pend_x) + int'($signed(it.delta_x)), -32768, 32767));
        pend_y = 16'(clip(int'(pend_y) + int'($signed(it.delta_y)), -32768, 32767));
      end
      OP_WARP: begin
        home_x = HOME_X_LOAD;
        home_y = HOME_Y_LOAD;
        seek_x = 1'b1;
        seek_y = 1'b1;
        pend_x = 16'(clip(int'($signed(it.target_x)), 0, int'(MAX_COL)));
        pend_y = 16'(clip(int'($signed(it.target_y)), 0, int'(MAX_ROW)));
        stall_cnt = 0;
        gen_warp = it.warp_tag;
      end
      OP_BUTTON: begin
        sel_bit = it.button_sel ? BTN_PRIMARY : BTN_SECONDARY;
        if (it.button_down) begin
          btn = btn & ~sel_bit;
        end else begin
          btn = btn | sel_bit;
        end
      end
      OP_PEEK: begin
        sx = 16'(clip(int'(home_x) + int'(pend_x), -32768, 32767));
        sy = 16'(clip(int'(home_y) + int'(pend_y), -32768, 32767));
      end
      OP_SYNC: begin
        hx = int'($signed(it.held_x));
        hy = int'($signed(it.held_y));
        limit = room_slow ? int'(ROOM_SLOW) : int'(ROOM_FAST);
        bypass = (stall_cnt >= STALL_LIM);
        if (bypass) bypass_syncs++;
        axis_advance(home_x, seek_x, pend_x, hx, limit, bypass, sx);
        axis_advance(home_y, seek_y, pend_y, hy, limit, bypass, sy);
        work = (home_x != 0) || (home_y != 0) || (pend_x != 0) || (pend_y != 0) ||
               seek_x || seek_y;
        held = (hx != 0) || (hy != 0);
        if (sx != 0 || sy != 0 || (!work && !held)) begin
          stall_cnt = 0;
        end else if (stall_cnt < STALL_LIM) begin
          stall_cnt++;
        end
        if (!work && sx == 0 && sy == 0 && (!held || stall_cnt >= STALL_LIM)) begin
          gen_done = gen_warp;
        end
      end
      OP_SOFT_RESET: begin
        clear_motion_state();
        gen_done = gen_warp;
      end
      default: begin
      end
    endcase
    rep.step_x = sx;
    rep.step_y = sy;
    rep.button_bits = btn;
    rep.warp_done_tag = gen_done;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    mmp_out_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = out_data;
        results_out++;
        if (queued_reports.size() == 0) begin
          report_mismatch("unexpected transaction", got.warp_done_tag, '0);
        end else begin
          want = queued_reports.pop_front();
          if (got.step_x !== want.step_x)
            report_mismatch("step_x", 32'(got.step_x), 32'(want.step_x));
          if (got.step_y !== want.step_y)
            report_mismatch("step_y", 32'(got.step_y), 32'(want.step_y));
          if (got.button_bits !== want.button_bits)
            report_mismatch("button_bits", 32'(got.button_bits), 32'(want.button_bits));
          if (got.warp_done_tag !== want.warp_done_tag)
            report_mismatch("warp_done_tag", got.warp_done_tag, want.warp_done_tag);
        end
      end
      if (in_valid && in_ready) begin
        advance_pacer(in_data, want);
        queued_reports.push_back(want);
        items_in++;
      end
    end
  end

  // receiver: ready pattern changes mode every so often, plus requested hold-offs
  always @(posedge clk) begin : receiver
    int rx_mode, mode_left, hold_left, phase;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 150);
      end else begin
        mode_left--;
      end
      phase++;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= phase[2];
      endcase
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

  function automatic mmp_in_t random_item(input logic [2:0] op);
    mmp_in_t it;
    it.op = op;
    it.delta_x = 16'($urandom);
    it.delta_y = 16'($urandom);
    it.target_x = 12'($urandom);
    it.target_y = 12'($urandom);
    it.warp_tag = $urandom;
    it.button_sel = 1'($urandom);
    it.button_down = 1'($urandom);
    it.held_x = 8'($urandom);
    it.held_y = 8'($urandom);
    return it;
  endfunction

  function automatic logic [7:0] pick_held();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 8'h00;
      5: return 8'h80;
      6: return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(input mmp_in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_paced(input mmp_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_item(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (queued_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_room_mode(input bit slow);
    cfg_we <= 1'b1;
    cfg_wdata <= slow;
    @(posedge clk);
    cfg_we <= 1'b0;
    room_slow = slow;
  endtask

  task automatic send_sync(input logic [7:0] hx, input logic [7:0] hy);
    mmp_in_t it;
    it = random_item(OP_SYNC);
    it.held_x = hx;
    it.held_y = hy;
    send_paced(it);
  endtask

  task automatic test_directed();
    mmp_in_t it;
    send_paced(random_item(OP_PEEK));
    // saturate pending counts high, then low
    it = random_item(OP_MOVE);
    it.delta_x = 16'sh7fff;
    it.delta_y = 16'sh7fff;
    send_paced(it);
    send_paced(it);
    send_paced(random_item(OP_PEEK));
    it.delta_x = -16'sh8000;
    it.delta_y = -16'sh8000;
    repeat (3) send_paced(it);
    send_paced(random_item(OP_PEEK));
    // press and release both buttons
    it = random_item(OP_BUTTON);
    it.button_down = 1'b1;
    it.button_sel = 1'b1;
    send_paced(it);
    it.button_sel = 1'b0;
    send_paced(it);
    it.button_down = 1'b0;
    it.button_sel = 1'b1;
    send_paced(it);
    it.button_sel = 1'b0;
    send_paced(it);
    // warp below the clamp, full latch and negative room
    it = random_item(OP_WARP);
    it.target_x = -12'sh800;
    it.target_y = -12'sh800;
    it.warp_tag = 32'hffff_ffff;
    send_paced(it);
    send_paced(random_item(OP_PEEK));
    send_sync(8'h80, 8'h80);
    send_sync(8'h7f, 8'h7f);
    repeat (3) send_sync(8'h00, 8'h00);
    // warp above the clamp, then wait on a held latch
    it.target_x = 12'sh7ff;
    it.target_y = 12'sh7ff;
    it.warp_tag = 32'h0;
    send_paced(it);
    repeat (2) send_sync(8'h00, 8'h00);
    send_sync(8'h05, 8'hfb);
    send_paced(random_item(OP_SPARE_6));
    send_paced(random_item(OP_SPARE_7));
    send_paced(random_item(OP_SOFT_RESET));
    send_paced(random_item(OP_PEEK));
  endtask

  task automatic test_random_traffic(input int n_items);
    mmp_in_t     it;
    int          sent, kind, len;
    logic [7:0]  stuck_x, stuck_y;
    bit          fixed_held;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // warp followed by a run of syncs, sometimes against a stuck latch
        send_paced(random_item(OP_WARP));
        sent++;
        len = $urandom_range(4, 90);
        fixed_held = ($urandom_range(0, 1) == 1);
        stuck_x = pick_held();
        stuck_y = pick_held();
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) begin
            it = random_item(3'($urandom_range(0, 3)));
            if (it.op == OP_WARP) it.op = OP_PEEK;
            send_paced(it);
          end else if (fixed_held) begin
            send_sync(stuck_x, stuck_y);
          end else begin
            send_sync(pick_held(), pick_held());
          end
          sent++;
        end
      end else if (kind < 7) begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          it = random_item(OP_MOVE);
          if ($urandom_range(0, 4) != 0) begin
            it.delta_x = 16'(int'($urandom_range(0, 600)) - 300);
            it.delta_y = 16'(int'($urandom_range(0, 600)) - 300);
          end
          send_paced(it);
          sent++;
        end
        len = $urandom_range(2, 20);
        repeat (len) begin
          send_sync(pick_held(), pick_held());
          sent++;
        end
      end else if (kind == 7) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          send_paced(random_item(($urandom_range(0, 1) == 1) ? OP_BUTTON : OP_PEEK));
          sent++;
        end
      end else if (kind == 8) begin
        len = $urandom_range(1, 5);
        repeat (len) begin
          send_paced(random_item(3'($urandom)));
          sent++;
        end
      end else begin
        case ($urandom_range(0, 2))
          0: send_paced(random_item(OP_SOFT_RESET));
          1: send_paced(random_item(OP_SPARE_6));
          default: send_paced(random_item(OP_SPARE_7));
        endcase
        sent++;
      end
    end
  endtask

  task automatic test_back_pressure();
    hold_req = 250;
    repeat (40) send_item(random_item(3'($urandom_range(0, 7))));
  endtask

  task automatic test_room_setting(input bit slow, input int n_items);
    settle();
    write_room_mode(slow);
    test_random_traffic(n_items);
  endtask

  initial begin : main
    room_slow = 1'b0;
    gen_warp = '0;
    gen_done = '0;
    clear_motion_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    settle();
    write_room_mode(1'b1);
    test_directed();
    test_room_setting(1'b1, 400);
    test_room_setting(1'b0, 400);
    test_back_pressure();
    test_room_setting(1'b1, 350);
    test_room_setting(1'b0, 350);
    settle();

    $display("covered %0d transactions in, %0d out, %0d syncs past the stall limit",
             items_in, results_out, bypass_syncs);
    $display("fast and slow room, warps, buttons, saturation, soft reset, back pressure");
    if (errors == 0 && queued_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
